[rtl/core/lbp_pkg.sv]
`timescale 1ns / 1ps

package lbp_pkg;

  localparam int unsigned ByteBits    = 8;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 6;
  localparam int unsigned MaxCount    = 32;
  localparam int unsigned RevMaxCount = 16;
  localparam int unsigned PendWidth   = 7;
  localparam int unsigned PendCntW    = 3;
  localparam int unsigned AccWidth    = ValueWidth + PendWidth;
  localparam int unsigned NBytesW     = 3;
  localparam int unsigned ByteIdxW    = 2;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    FuncAppend    = 2'd0,
    FuncAppendRev = 2'd1,
    FuncFlush     = 2'd2
  } func_e;

  // One queued job: the bytes to emit, lowest byte first, and how many (1 to 4).
  typedef struct packed {
    logic [ValueWidth-1:0] data;
    logic [NBytesW-1:0]    nbytes;
  } job_t;

endpackage

[rtl/core/lbp_if.sv]
`timescale 1ns / 1ps

interface lbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  bit_count;
  logic [31:0] bit_value;

  modport source (output valid, func, bit_count, bit_value, input ready);
  modport sink (input valid, func, bit_count, bit_value, output ready);
endinterface

interface lbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last;

  modport source (output valid, byte_out, last, input ready);
  modport sink (input valid, byte_out, last, output ready);
endinterface

[rtl/core/lbp_front.sv]
`timescale 1ns / 1ps

module lbp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbp_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output lbp_pkg::job_t job_o
);
  import lbp_pkg::*;

  logic [PendWidth-1:0]  pend_q, pend_d;
  logic [PendCntW-1:0]   pcnt_q, pcnt_d;
  logic                  accept;
  logic [15:0]           rev;
  logic [4:0]            n_rev;
  logic [CountWidth-1:0] n_app;
  logic [CountWidth-1:0] n_eff;
  logic [ValueWidth:0]   mask;
  logic [ValueWidth-1:0] src;
  logic [AccWidth-1:0]   acc;
  logic [AccWidth-1:0]   rest;
  logic [CountWidth-1:0] total;
  logic [NBytesW-1:0]    nbytes;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rev[i] = in_i.bit_value[15-i];
    end
  end

  assign n_rev = (in_i.bit_count > CountWidth'(RevMaxCount)) ? 5'(RevMaxCount)
                                                            : in_i.bit_count[4:0];
  assign n_app = (in_i.bit_count > CountWidth'(MaxCount)) ? CountWidth'(MaxCount)
                                                         : in_i.bit_count;
  assign mask  = ({{ValueWidth{1'b0}}, 1'b1} << n_app) - {{ValueWidth{1'b0}}, 1'b1};

  always_comb begin
    if (in_i.func == FuncAppendRev) begin
      // mirror all 16 bits, then drop the ones beyond the count
      src   = {16'b0, rev >> (5'd16 - n_rev)};
      n_eff = {1'b0, n_rev};
    end else begin
      src   = in_i.bit_value & mask[ValueWidth-1:0];
      n_eff = n_app;
    end
  end

  assign acc    = ({{PendWidth{1'b0}}, src} << pcnt_q) | {{ValueWidth{1'b0}}, pend_q};
  assign total  = {{(CountWidth-PendCntW){1'b0}}, pcnt_q} + n_eff;
  assign nbytes = total[CountWidth-1:PendCntW];
  assign rest   = acc >> {nbytes, 3'b000};

  always_comb begin
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    push_o      = 1'b0;
    job_o.data  = acc[ValueWidth-1:0];
    job_o.nbytes = nbytes;
    if (accept) begin
      unique case (in_i.func)
        FuncAppend, FuncAppendRev: begin
          pend_d = rest[PendWidth-1:0];
          pcnt_d = total[PendCntW-1:0];
          push_o = (nbytes != '0);
        end
        FuncFlush: begin
          pend_d       = '0;
          pcnt_d       = '0;
          push_o       = (pcnt_q != '0);
          job_o.data   = {{(ValueWidth-PendWidth){1'b0}}, pend_q};
          job_o.nbytes = NBytesW'(1);
        end
        default: begin
          // unused code: drop the item
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

`ifndef SYNTHESIS
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == FuncFlush) |=> (pcnt_q == '0 && pend_q == '0))
    else $error("pending bits not cleared by flush");
`endif

endmodule

[rtl/core/lbp_queue.sv]
`timescale 1ns / 1ps

module lbp_queue #(
  parameter int unsigned DEPTH = lbp_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lbp_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lbp_pkg::job_t head_o
);
  import lbp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("job popped from empty queue");
`endif

endmodule

[rtl/core/lbp_back.sv]
`timescale 1ns / 1ps

module lbp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  lbp_pkg::job_t head_i,
  output logic          pop_o,
  lbp_out_if.source     out_o
);
  import lbp_pkg::*;

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                xfer;
  logic                is_last;

  assign is_last        = ({1'b0, idx_q} == (head_i.nbytes - NBytesW'(1)));
  assign out_o.valid    = !empty_i;
  assign out_o.byte_out = head_i.data[{idx_q, 3'b000} +: ByteBits];
  assign out_o.last     = is_last;
  assign xfer           = out_o.valid && out_o.ready;
  assign pop_o          = xfer && is_last;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      // advance through the job, restart at the next one
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, idx_q} < head_i.nbytes))
    else $error("byte index beyond job length");
  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0))
    else $error("byte index not restarted after last byte");
`endif

endmodule

[rtl/core/lsb_first_bit_packer_unit.sv]
// LSB-first bit packer.
// in_i carries items: func (append, reversed append, flush), bit_count and
// bit_value. out_o emits the completed bytes, earliest bits in the low
// positions, with last set on the final byte that one item produces.
// An item is taken whenever the two-entry job queue has room; its pending-bit
// update finishes in the cycle it is taken, so items may arrive back to back.
// Each item that completes bytes turns into one job of 1 to 4 bytes; the
// output side drains one byte per cycle while the receiver is ready, and
// a job is popped after its last byte. A job's first byte is offered once
// the job is registered in the queue and the jobs ahead of it have drained.
// Items that make no byte (short appends, flush with nothing pending, the
// unused func code) leave no trace at the output.
// When the receiver stalls, the current byte holds; the queue fills and
// then in_i.ready drops until a job completes.
// Reset clears the pending bits, the queue and the byte index.
`timescale 1ns / 1ps

module lsb_first_bit_packer_unit #(
  parameter int unsigned QUEUE_DEPTH = lbp_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbp_in_if.sink    in_i,
  lbp_out_if.source out_o
);
  import lbp_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t push_job;
  job_t head_job;

  lbp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  lbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_job)
  );

  lbp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
